@@ design/wavetable_voice_oscillator_assert.svh @@
// Assertion macros used by the RTL.
// Each macro needs aclk and aresetn in the scope where it is used.
`ifndef WAVETABLE_VOICE_OSCILLATOR_ASSERT_SVH
`define WAVETABLE_VOICE_OSCILLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define WVO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wvo: same-cycle check failed");

// Next-cycle implication
`define WVO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wvo: next-cycle check failed");

`else

`define WVO_ASSERT_IMP(lbl, ante, cons)
`define WVO_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ design/wvo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wvo_pkg;

    // Shared multiplier operand and product
    typedef logic signed [24:0] op_t;
    typedef logic signed [49:0] prod_t;

    // Item actions
    typedef logic [1:0] action_t;
    localparam action_t ACT_WRITE_BASE   = 2'd0;
    localparam action_t ACT_WRITE_SECOND = 2'd1;
    localparam action_t ACT_TICK         = 2'd2;
    localparam action_t ACT_RESET_PHASES = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_MIX          = 1'b0;
    localparam logic REG_PHASE_OFFSET = 1'b1;

    // Q1.15 unity
    localparam logic [15:0] UNITY = 16'h8000;

    localparam prod_t SAT_HI = 50'sd32767;
    localparam prod_t SAT_LO = -50'sd32768;

    // Saturate to Q1.15
    function automatic logic signed [15:0] sat16(input prod_t v);
        if (v > SAT_HI) begin
            return 16'sh7fff;
        end else if (v < SAT_LO) begin
            return -16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    // Round (ties up) by 2^15, then saturate
    function automatic logic signed [15:0] rnd15_sat(input prod_t v);
        prod_t t;
        t = (v + prod_t'(16384)) >>> 15;
        return sat16(t);
    endfunction

    // s0 + round(prod / 2^24); result lies between the two samples
    function automatic logic signed [15:0] interp(input logic signed [15:0] s0, input prod_t p);
        prod_t t;
        logic [16:0] r;
        t = (p + prod_t'(1 << 23)) >>> 24;
        r = {s0[15], s0} + t[16:0];
        return r[15:0];
    endfunction

    // round((a + b) / 2), ties up
    function automatic logic signed [15:0] avg_round(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [17:0] s;
        s = 18'(a) + 18'(b) + 18'sd1;
        return s[16:1];
    endfunction

endpackage

`default_nettype wire

@@ design/wavetable_voice_oscillator.sv @@
// A tick item runs S_PH to S_SAT, repeating S_POS to S_XE when phase offset is set; its sample
// is registered in S_SAT once the output is free. The shared multiplier and one read port per
// table mean no item is taken while a tick runs; table writes and phase resets leave it idle.
// Reset: aresetn (synchronous, active low) clears voice phases, mix, phase offset and the
// output valid; table contents are kept and undefined until written.
`timescale 1ns / 1ps
`default_nettype none

`include "wavetable_voice_oscillator_assert.svh"

module wavetable_voice_oscillator
    import wvo_pkg::*;
#(
    parameter int TABLE_LEN  = 2048,
    parameter int NUM_VOICES = 16,
    localparam int IDX_W = $clog2(TABLE_LEN)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // APB configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    // Input items
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_action,
    input  wire logic [3:0]              s_voice,
    input  wire logic [IDX_W-1:0]        s_table_index,
    input  wire logic signed [15:0]      s_table_value,
    input  wire logic [23:0]             s_phase_step,
    input  wire logic [15:0]             s_voice_gain,
    // Result items
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [15:0]           m_sample
);

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PH, S_POS, S_ADDR, S_RD0, S_RD1, S_IB, S_IS,
        S_XB, S_XS, S_XE, S_GAIN, S_SAT
    } state_t;

    state_t state_reg, state_next;

    // Config registers
    logic [15:0] mix_reg;
    logic [23:0] phase_offset_reg;

    // Control
    logic [NUM_VOICES-1:0] vld_reg;
    logic                  pass_reg;
    logic                  m_valid_reg;
    logic                  ph_vld_reg;

    // Datapath
    logic [VW-1:0]      voice_reg;
    logic [23:0]        step_reg;
    logic [15:0]        gain_reg;
    logic [23:0]        base_phase_reg;
    logic [23:0]        rd_phase_reg;
    logic [23:0]        frac_reg;
    logic [IDX_W-1:0]   nxt_reg;
    logic signed [15:0] b0_reg, b1_reg, s0_reg, s1_reg;
    logic signed [15:0] bint_reg, sint_reg;
    logic signed [15:0] y0_reg, yf_reg;
    logic signed [15:0] m_sample_reg;
    prod_t              acc_reg;

    // Accept and decode
    logic          accept;
    logic          voice_ok;
    logic [VW-1:0] vidx_in;
    logic          cfg_wr;
    logic          out_free;
    logic          tick_go;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign voice_ok = (32'(s_voice) < NUM_VOICES);
    assign vidx_in  = VW'(s_voice);
    assign tick_go  = accept && (s_action == ACT_TICK) && voice_ok;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_valid_reg || m_ready;

    // Clamped weights
    logic [15:0] mix_c;
    logic [15:0] gain_in_c;
    assign mix_c     = (mix_reg > UNITY) ? UNITY : mix_reg;
    assign gain_in_c = (s_voice_gain > UNITY) ? UNITY : s_voice_gain;

    // Shared multiplier
    op_t   op_a, op_b;
    prod_t prod;

    wvo_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Table position from product
    logic [IDX_W-1:0] idx_w;
    logic [IDX_W-1:0] nxt_w;
    assign idx_w = prod[24 +: IDX_W];
    assign nxt_w = (idx_w == IDX_W'(TABLE_LEN - 1)) ? '0 : idx_w + 1'b1;

    logic signed [16:0] diff_b, diff_s;
    assign diff_b = {b1_reg[15], b1_reg} - {b0_reg[15], b0_reg};
    assign diff_s = {s1_reg[15], s1_reg} - {s0_reg[15], s0_reg};

    // Operand select per step
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_POS: begin
                op_a = {1'b0, rd_phase_reg};
                op_b = op_t'(TABLE_LEN);
            end
            S_IB: begin
                op_a = {1'b0, frac_reg};
                op_b = {{8{diff_b[16]}}, diff_b};
            end
            S_IS: begin
                op_a = {1'b0, frac_reg};
                op_b = {{8{diff_s[16]}}, diff_s};
            end
            S_XB: begin
                op_a = {{9{bint_reg[15]}}, bint_reg};
                op_b = {8'b0, {1'b0, UNITY} - {1'b0, mix_c}};
            end
            S_XS: begin
                op_a = {{9{sint_reg[15]}}, sint_reg};
                op_b = {9'b0, mix_c};
            end
            // Gain product; held while the result waits for the output
            S_GAIN, S_SAT: begin
                op_a = {{9{yf_reg[15]}}, yf_reg};
                op_b = {9'b0, gain_reg};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Table memories
    logic             base_we, second_we;
    logic [IDX_W-1:0] tab_raddr;
    logic [15:0]      base_rdata, second_rdata;
    logic             index_ok;

    assign index_ok  = (32'(s_table_index) < TABLE_LEN);
    assign base_we   = accept && (s_action == ACT_WRITE_BASE) && index_ok;
    assign second_we = accept && (s_action == ACT_WRITE_SECOND) && index_ok;
    assign tab_raddr = (state_reg == S_RD0) ? nxt_reg : idx_w;

    wvo_ram #(.WIDTH(16), .DEPTH(TABLE_LEN)) u_base_ram (
        .aclk  (aclk),
        .we    (base_we),
        .waddr (s_table_index),
        .wdata (s_table_value),
        .raddr (tab_raddr),
        .rdata (base_rdata)
    );

    wvo_ram #(.WIDTH(16), .DEPTH(TABLE_LEN)) u_second_ram (
        .aclk  (aclk),
        .we    (second_we),
        .waddr (s_table_index),
        .wdata (s_table_value),
        .raddr (tab_raddr),
        .rdata (second_rdata)
    );

    // Phase memory; vld_reg marks entries written since the last clear
    logic        phase_we;
    logic [23:0] phase_wdata;
    logic [23:0] phase_rdata;

    assign phase_we    = (state_reg == S_SAT) && out_free;
    assign phase_wdata = base_phase_reg + step_reg;

    wvo_ram #(.WIDTH(24), .DEPTH(NUM_VOICES)) u_phase_ram (
        .aclk  (aclk),
        .we    (phase_we),
        .waddr (voice_reg),
        .wdata (phase_wdata),
        .raddr (vidx_in),
        .rdata (phase_rdata)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (tick_go) begin
                    state_next = S_PH;
                end
            end
            S_PH:   state_next = S_POS;
            S_POS:  state_next = S_ADDR;
            S_ADDR: state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_IB;
            S_IB:   state_next = S_IS;
            S_IS:   state_next = S_XB;
            S_XB:   state_next = S_XS;
            S_XS:   state_next = S_XE;
            S_XE: begin
                if (!pass_reg && (phase_offset_reg != '0)) begin
                    state_next = S_POS;
                end else begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN: state_next = S_SAT;
            S_SAT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [15:0] xf_w;
    assign xf_w = rnd15_sat(acc_reg + prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            mix_reg          <= '0;
            phase_offset_reg <= '0;
            vld_reg          <= '0;
            pass_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Config writes
            if (cfg_wr) begin
                if (paddr[2] == REG_MIX) begin
                    mix_reg <= pwdata[15:0];
                end else begin
                    phase_offset_reg <= pwdata[23:0];
                end
            end

            // Phase valid bits
            if (accept && (s_action == ACT_RESET_PHASES)) begin
                vld_reg <= '0;
            end else if (phase_we) begin
                vld_reg[voice_reg] <= 1'b1;
            end

            // PWM pass flag
            if (state_reg == S_XE && !pass_reg && (phase_offset_reg != '0)) begin
                pass_reg <= 1'b1;
            end else if (state_reg == S_SAT) begin
                pass_reg <= 1'b0;
            end

            // Output valid
            if (phase_we) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // Latch tick fields
        if (state_reg == S_IDLE) begin
            voice_reg  <= vidx_in;
            step_reg   <= s_phase_step;
            gain_reg   <= gain_in_c;
            ph_vld_reg <= voice_ok && vld_reg[vidx_in];
        end

        case (state_reg)
            S_PH: begin
                base_phase_reg <= ph_vld_reg ? phase_rdata : '0;
                rd_phase_reg   <= ph_vld_reg ? phase_rdata : '0;
            end
            S_ADDR: begin
                frac_reg <= prod[23:0];
                nxt_reg  <= nxt_w;
            end
            S_RD0: begin
                b0_reg <= base_rdata;
                s0_reg <= second_rdata;
            end
            S_RD1: begin
                b1_reg <= base_rdata;
                s1_reg <= second_rdata;
            end
            S_IS: bint_reg <= interp(b0_reg, prod);
            S_XB: sint_reg <= interp(s0_reg, prod);
            S_XS: acc_reg  <= prod;
            S_XE: begin
                if (!pass_reg && (phase_offset_reg != '0)) begin
                    y0_reg       <= xf_w;
                    rd_phase_reg <= base_phase_reg + phase_offset_reg;
                end else if (pass_reg) begin
                    yf_reg <= avg_round(y0_reg, xf_w);
                end else begin
                    yf_reg <= xf_w;
                end
            end
            S_SAT: begin
                if (out_free) begin
                    m_sample_reg <= rnd15_sat(prod);
                end
            end
            default: begin
            end
        endcase
    end

    // Register readback
    always_comb begin
        if (paddr[2] == REG_PHASE_OFFSET) begin
            prdata = {8'b0, phase_offset_reg};
        end else begin
            prdata = {16'b0, mix_reg};
        end
    end

    assign pready   = 1'b1;
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // Checks
    `WVO_ASSERT_NXT(a_tick_starts, tick_go, state_reg == S_PH)
    `WVO_ASSERT_IMP(a_valid_from_sat, $rose(m_valid_reg), $past(state_reg) == S_SAT)
    `WVO_ASSERT_IMP(a_pass_needs_offset, pass_reg, phase_offset_reg != '0)
    `WVO_ASSERT_IMP(a_idx_range, state_reg == S_ADDR, 32'(idx_w) < TABLE_LEN)

endmodule

`default_nettype wire

@@ design/wvo_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wvo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/wvo_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wvo_mul
    import wvo_pkg::*;
(
    input  wire logic aclk,
    input  wire op_t  op_a,
    input  wire op_t  op_b,
    output prod_t     prod
);

    prod_t prod_reg;

    // Signed 25x25 multiply, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
